[rtl/core/rth_pkg.sv]
// Package: shared types, constants and helpers for the RGB to HSI pixel core.
`default_nettype none
package rth_pkg;

	localparam int CHANNEL_BITS = 8;
	localparam int SUM_BITS     = CHANNEL_BITS + 2;
	localparam int DIFF_BITS    = CHANNEL_BITS + 3;
	localparam int HUE_BITS     = 15;
	localparam int SAT_BITS     = 13;
	localparam int INT_BITS     = 10;

	localparam int MID_DEPTH    = 4;
	localparam int OUT_DEPTH    = 2;

	localparam int CORDIC_STEPS = 20;
	localparam int QUO_BITS     = 13;
	localparam int VEC_BITS     = 27;
	localparam int ANG_BITS     = 26;
	localparam int REM_BITS     = 24;
	localparam int DIVD_BITS    = 23;
	localparam int YPROD_BITS   = 23;

	localparam logic [14:0] SQRT3_Q14     = 15'd28378;
	localparam logic [14:0] SAT_SCALE     = 15'd24576;
	localparam logic [15:0] THIRD_RECIP   = 16'd43691;
	localparam int          THIRD_SHIFT   = 17;
	localparam logic signed [ANG_BITS-1:0] DEG90_Q16  = 26'sd5898240;
	localparam logic signed [ANG_BITS-1:0] DEG180_Q16 = 26'sd11796480;
	localparam logic [HUE_BITS-1:0] FULL_TURN_Q6 = 15'd23040;
	localparam logic [SAT_BITS-1:0] SAT_ONE      = 13'd4096;

	localparam logic signed [ANG_BITS-1:0] ATAN_DEG_Q16 [CORDIC_STEPS] = '{
		26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945, 26'sd234379,
		26'sd117264,  26'sd58666,   26'sd29335,  26'sd14668,  26'sd7334,
		26'sd3667,    26'sd1833,    26'sd917,    26'sd458,    26'sd229,
		26'sd115,     26'sd57,      26'sd29,     26'sd14,     26'sd7
	};

	typedef struct packed {
		logic [SUM_BITS-1:0]         sum;
		logic signed [DIFF_BITS-1:0] x;
		logic [CHANNEL_BITS-1:0]     d;
		logic [DIVD_BITS-1:0]        dividend;
		logic                        bgt;
		logic                        gray;
		logic                        last;
	} mid_item_t;

	typedef struct packed {
		logic signed [VEC_BITS-1:0] x;
		logic signed [VEC_BITS-1:0] y;
		logic signed [ANG_BITS-1:0] z;
		logic [REM_BITS-1:0]        rem;
		logic [QUO_BITS-1:0]        quo;
		logic [SUM_BITS-1:0]        sum;
		logic                       bgt;
		logic                       gray;
		logic                       last;
	} stage_t;

	typedef struct packed {
		logic [HUE_BITS-1:0] hue;
		logic [SAT_BITS-1:0] sat;
		logic [INT_BITS-1:0] inten;
		logic                last;
	} out_item_t;

	// shift toward zero so negative values mirror positive ones
	function automatic logic signed [VEC_BITS-1:0] shr_tz(
		input logic signed [VEC_BITS-1:0] v, input int s);
		logic signed [VEC_BITS-1:0] m;
		begin
			m = v < 0 ? -v : v;
			m = m >>> s;
			return v < 0 ? -m : m;
		end
	endfunction

endpackage
`default_nettype wire

[rtl/core/rth_fifo.sv]
// Small register queue used between the front and back and at the result side.
`default_nettype none
module rth_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             rd_en,
	output logic [WIDTH-1:0]      rd_data,
	output logic                  empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr, do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

[rtl/core/rth_front.sv]
// Front end: classify a pixel and form the operands for the back end.
`default_nettype none
module rth_front (
	input  wire logic [rth_pkg::CHANNEL_BITS-1:0] red,
	input  wire logic [rth_pkg::CHANNEL_BITS-1:0] green,
	input  wire logic [rth_pkg::CHANNEL_BITS-1:0] blue,
	input  wire logic                             last,
	output rth_pkg::mid_item_t                    item
);
	localparam int CB = rth_pkg::CHANNEL_BITS;
	localparam int DB = rth_pkg::DIFF_BITS;
	localparam int SB = rth_pkg::SUM_BITS;

	logic [CB-1:0] mn;

	always_comb begin
		mn = red;
		if (blue < mn) begin
			mn = blue;
		end
		if (green < mn) begin
			mn = green;
		end
		item.sum  = SB'(red) + SB'(green) + SB'(blue);
		item.x    = (DB'(red) <<< 1) - DB'(green) - DB'(blue);
		item.d    = (green > blue) ? green - blue : blue - green;
		item.bgt  = blue > green;
		item.gray = (red == green) && (green == blue);
		item.last = last;
		// 3*min*4096*2 + sum, numerator of the rounded ratio
		item.dividend = rth_pkg::DIVD_BITS'(mn)
			* rth_pkg::DIVD_BITS'(rth_pkg::SAT_SCALE)
			+ rth_pkg::DIVD_BITS'(item.sum);
	end
endmodule
`default_nettype wire

[rtl/core/rth_back.sv]
// Back end: CORDIC angle pipeline with pipelined divider and output formatting.
`default_nettype none
module rth_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  rth_pkg::mid_item_t in_item,
	input  wire logic          in_empty,
	output logic               in_pop,
	input  wire logic          out_full,
	output logic               out_push,
	output rth_pkg::out_item_t out_item
);
	localparam int N  = rth_pkg::CORDIC_STEPS;
	localparam int VB = rth_pkg::VEC_BITS;
	localparam int AB = rth_pkg::ANG_BITS;
	localparam int RB = rth_pkg::REM_BITS;
	localparam int QB = rth_pkg::QUO_BITS;

	rth_pkg::stage_t st_q [0:N];
	rth_pkg::stage_t nxt  [1:N];
	rth_pkg::stage_t prep;
	logic            vld_q [0:N];
	logic            adv;

	// stall the whole line only when a finished item cannot leave
	assign adv      = !(vld_q[N] && out_full);
	assign in_pop   = adv && !in_empty;
	assign out_push = vld_q[N] && !out_full;

	always_comb begin
		logic signed [VB-1:0] bx, by;
		bx = VB'(in_item.x) <<< 14;
		by = VB'(rth_pkg::YPROD_BITS'(in_item.d)
			* rth_pkg::YPROD_BITS'(rth_pkg::SQRT3_Q14));
		prep.rem  = RB'(in_item.dividend);
		prep.quo  = '0;
		prep.sum  = in_item.sum;
		prep.bgt  = in_item.bgt;
		prep.gray = in_item.gray;
		prep.last = in_item.last;
		if (bx < 0) begin
			// turn by -90 degrees into the right half plane
			prep.x = by;
			prep.y = -bx;
			prep.z = rth_pkg::DEG90_Q16;
		end else begin
			prep.x = bx;
			prep.y = by;
			prep.z = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_q[0] <= prep;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q[0] <= 1'b0;
		end else if (adv) begin
			vld_q[0] <= !in_empty;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_step
		localparam int QI = (i < QB) ? (QB - 1 - i) : 0;

		always_comb begin
			logic signed [VB-1:0] xs, ys;
			logic [RB-1:0]        dsh;
			xs = rth_pkg::shr_tz(st_q[i].x, i);
			ys = rth_pkg::shr_tz(st_q[i].y, i);
			nxt[i+1] = st_q[i];
			if (st_q[i].y > 0) begin
				nxt[i+1].x = st_q[i].x + ys;
				nxt[i+1].y = st_q[i].y - xs;
				nxt[i+1].z = st_q[i].z + rth_pkg::ATAN_DEG_Q16[i];
			end else begin
				nxt[i+1].x = st_q[i].x - ys;
				nxt[i+1].y = st_q[i].y + xs;
				nxt[i+1].z = st_q[i].z - rth_pkg::ATAN_DEG_Q16[i];
			end
			// one restoring quotient bit, most significant first
			dsh = '0;
			if (i < QB) begin
				dsh = (RB'(st_q[i].sum) << 1) << QI;
				if (st_q[i].rem >= dsh) begin
					nxt[i+1].rem = st_q[i].rem - dsh;
					nxt[i+1].quo[QI] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				st_q[i+1] <= nxt[i+1];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[i+1] <= 1'b0;
			end else if (adv) begin
				vld_q[i+1] <= vld_q[i];
			end
		end
	end

	always_comb begin
		logic signed [AB-1:0]        zc;
		logic [AB-1:0]               zr;
		logic [rth_pkg::HUE_BITS-1:0] h;
		logic [27:0]                 ip;
		zc = st_q[N].z;
		if (zc < 0) begin
			zc = '0;
		end
		if (zc > rth_pkg::DEG180_Q16) begin
			zc = rth_pkg::DEG180_Q16;
		end
		zr = (AB'(zc) + AB'(512)) >> 10;
		h  = rth_pkg::HUE_BITS'(zr);
		if (st_q[N].bgt) begin
			h = rth_pkg::FULL_TURN_Q6 - h;
		end
		if (h >= rth_pkg::FULL_TURN_Q6) begin
			h = h - rth_pkg::FULL_TURN_Q6;
		end
		out_item.hue = st_q[N].gray ? '0 : h;
		out_item.sat = (st_q[N].quo >= rth_pkg::SAT_ONE) ? '0
			: rth_pkg::SAT_ONE - st_q[N].quo;
		ip = ((12'(st_q[N].sum) << 2) + 12'd1) * rth_pkg::THIRD_RECIP;
		out_item.inten = rth_pkg::INT_BITS'(ip >> rth_pkg::THIRD_SHIFT);
		out_item.last  = st_q[N].last;
	end
endmodule
`default_nettype wire

[rtl/core/rgb_to_hsi_pixel_core.sv]
// Top level: RGB to HSI pixel converter with queue style ports.
//
//   channel  | handshake          | payload
//   ---------+--------------------+----------------------------------------
//   pixel in | push / full        | red_in, green_in, blue_in, last_in
//   result   | pop / empty        | hue_out, sat_out, int_out, last_out
//
// One pixel per cycle sustained while the result queue has room. A pixel
// passes the operand register, the 20 CORDIC stages and the result queue write.
// The 20 stage CORDIC line, with the saturation divider folded into its
// first 13 stages, sets the latency. A full result queue stalls the line;
// the middle queue then fills and raises full. Reset empties both queues.
`default_nettype none
module rgb_to_hsi_pixel_core #(
	parameter int MID_DEPTH = rth_pkg::MID_DEPTH,
	parameter int OUT_DEPTH = rth_pkg::OUT_DEPTH
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	output logic                               full,
	input  wire logic [7:0]                    red_in,
	input  wire logic [7:0]                    green_in,
	input  wire logic [7:0]                    blue_in,
	input  wire logic                          last_in,
	input  wire logic                          pop,
	output logic                               empty,
	output logic [rth_pkg::HUE_BITS-1:0]       hue_out,
	output logic [rth_pkg::SAT_BITS-1:0]       sat_out,
	output logic [rth_pkg::INT_BITS-1:0]       int_out,
	output logic                               last_out
);
	rth_pkg::mid_item_t front_item, mid_head;
	rth_pkg::out_item_t back_item, out_head;
	logic               mid_empty, mid_pop, out_full, out_push;

	rth_front u_front (
		.red   (red_in[rth_pkg::CHANNEL_BITS-1:0]),
		.green (green_in[rth_pkg::CHANNEL_BITS-1:0]),
		.blue  (blue_in[rth_pkg::CHANNEL_BITS-1:0]),
		.last  (last_in),
		.item  (front_item)
	);

	rth_fifo #(
		.WIDTH ($bits(rth_pkg::mid_item_t)),
		.DEPTH (MID_DEPTH)
	) u_mid_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (front_item),
		.full    (full),
		.rd_en   (mid_pop),
		.rd_data (mid_head),
		.empty   (mid_empty)
	);

	rth_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_item  (mid_head),
		.in_empty (mid_empty),
		.in_pop   (mid_pop),
		.out_full (out_full),
		.out_push (out_push),
		.out_item (back_item)
	);

	rth_fifo #(
		.WIDTH ($bits(rth_pkg::out_item_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (out_push),
		.wr_data (back_item),
		.full    (out_full),
		.rd_en   (pop),
		.rd_data (out_head),
		.empty   (empty)
	);

	assign hue_out  = out_head.hue;
	assign sat_out  = out_head.sat;
	assign int_out  = out_head.inten;
	assign last_out = out_head.last;
endmodule
`default_nettype wire
